FILE: src/pid_pkg.sv
package pid_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned DtW = 24;
	localparam int unsigned FracBits = 16;
	localparam int unsigned DtMinStep = 1678;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned DivQW = 57;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_SET    = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P   = 3'd0,
		REG_GAIN_I   = 3'd1,
		REG_GAIN_D   = 3'd2,
		REG_INT_LIM  = 3'd3,
		REG_OUT_LOW  = 3'd4,
		REG_OUT_HIGH = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_DT,
		ST_INTEG,
		ST_DIV,
		ST_DSAT,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_CLAMP,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic do_set;
		logic do_clear;
		logic calc_err;
		logic mul_dt;
		logic integ;
		logic div_start;
		logic div_step;
		logic dsat;
		logic mul_p;
		logic mul_i;
		logic mul_d;
		logic clamp;
	} pid_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic   div_done;
		kind_t  kind;
	} pid_sts_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] mx;
		logic signed [65:0] mn;
		mx = 66'sd2147483647;
		mn = -66'sd2147483648;
		if (x > mx) begin
			sat32 = 32'sh7fffffff;
		end else if (x < mn) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = x[DataW-1:0];
		end
	endfunction

endpackage

FILE: src/pid_if.sv
interface pid_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/pid_ctrl.sv
module pid_ctrl import pid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  pid_sts_t sts,
	output pid_cmd_t cmd
);

	state_t state_q, state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_ERR;
			end
			ST_ERR: begin
				if (sts.kind == KIND_SAMPLE) state_d = ST_MUL_DT;
				else state_d = ST_IDLE;
			end
			ST_MUL_DT: state_d = ST_INTEG;
			ST_INTEG: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_done) state_d = ST_DSAT;
			end
			ST_DSAT: state_d = ST_MUL_P;
			ST_MUL_P: state_d = ST_MUL_I;
			ST_MUL_I: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ERR: begin
				cmd.calc_err = (sts.kind == KIND_SAMPLE);
				cmd.do_set = (sts.kind == KIND_SET);
				cmd.do_clear = (sts.kind == KIND_CLEAR);
			end
			ST_MUL_DT: cmd.mul_dt = 1'b1;
			ST_INTEG: begin
				cmd.integ = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_DSAT: cmd.dsat = 1'b1;
			ST_MUL_P: cmd.mul_p = 1'b1;
			ST_MUL_I: cmd.mul_i = 1'b1;
			ST_MUL_D: cmd.mul_d = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	a_out_after_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_CLAMP)) else $error("result without clamp");
	a_div_before_dsat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSAT) |-> $past(sts.div_done)) else $error("derivative before divide");

endmodule

FILE: src/pid_dpath.sv
module pid_dpath import pid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pid_cmd_t              cmd,
	output pid_sts_t              sts,
	input  logic [1:0]            in_kind,
	input  logic signed [DataW-1:0] in_value,
	input  logic [DtW-1:0]        in_dt,
	input  logic                  cfg_we,
	input  logic [CfgIdxW-1:0]    cfg_idx,
	input  logic [DataW-1:0]      cfg_data,
	output logic signed [DataW-1:0] drive
);

	logic signed [DataW-1:0] gp_q, gi_q, gd_q, lo_q, hi_q;
	logic [DataW-2:0]        lim_q;
	logic signed [DataW-1:0] target_q, last_q, sum_q, err_q, deriv_q, drive_q;
	kind_t                   kind_q;
	logic signed [DataW-1:0] val_q;
	logic [DtW-1:0]          dt_q;
	logic signed [65:0]      prod_q;
	logic signed [65:0]      acc_q;
	// Divider: unsigned restoring, one quotient bit per cycle.
	logic [DivQW-1:0]        quo_q;
	logic [DtW:0]            rem_q;
	logic [5:0]              cnt_q;
	logic                    neg_q, dz_q;

	logic signed [DataW:0]   diff;
	logic [DataW:0]          mag;
	logic signed [DataW:0]   errw;
	logic signed [65:0]      integ_w, lim_w;
	logic [DtW:0]            rem_sh;
	logic signed [65:0]      qs;
	logic signed [DataW-1:0] mul_a, mul_b;
	logic signed [63:0]      mul_r;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q <= '0;
			gi_q <= '0;
			gd_q <= '0;
			lim_q <= '1;
			lo_q <= 32'sh80000000;
			hi_q <= 32'sh7fffffff;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GAIN_P: gp_q <= cfg_data;
				REG_GAIN_I: gi_q <= cfg_data;
				REG_GAIN_D: gd_q <= cfg_data;
				REG_INT_LIM: lim_q <= cfg_data[DataW-2:0];
				REG_OUT_LOW: lo_q <= cfg_data;
				REG_OUT_HIGH: hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier, one product per cycle.
	always_comb begin
		mul_a = err_q;
		mul_b = $signed({8'd0, dt_q});
		if (cmd.mul_p) begin
			mul_a = gp_q;
		end else if (cmd.mul_i) begin
			mul_a = gi_q;
			mul_b = sum_q;
		end else if (cmd.mul_d) begin
			mul_a = gd_q;
			mul_b = deriv_q;
		end
		if (cmd.mul_p) mul_b = err_q;
		mul_r = mul_a * mul_b;
	end

	assign errw = $signed({target_q[DataW-1], target_q}) - $signed({val_q[DataW-1], val_q});
	assign diff = $signed({err_q[DataW-1], err_q}) - $signed({last_q[DataW-1], last_q});
	assign mag = diff[DataW] ? (DataW+1)'(0) - diff : diff;
	assign integ_w = 66'(sum_q) + (prod_q >>> DtW);
	assign lim_w = $signed({35'd0, lim_q});
	assign rem_sh = {rem_q[DtW-1:0], quo_q[DivQW-1]};
	assign qs = neg_q ? -$signed({9'd0, quo_q}) : $signed({9'd0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			last_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.do_set) begin
				target_q <= val_q;
				sum_q <= '0;
			end
			if (cmd.do_clear) begin
				sum_q <= '0;
				last_q <= '0;
			end
			if (cmd.integ) begin
				if (integ_w > lim_w) sum_q <= $signed({1'b0, lim_q});
				else if (integ_w < -lim_w) sum_q <= -$signed({1'b0, lim_q});
				else sum_q <= integ_w[DataW-1:0];
				last_q <= err_q;
			end
		end
	end

	// Working registers of one sample.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(in_kind);
			val_q <= in_value;
			dt_q <= in_dt;
		end
		if (cmd.calc_err) err_q <= sat32(66'(errw));
		if (cmd.mul_dt) prod_q <= 66'(mul_r);
		if (cmd.div_start) begin
			quo_q <= {mag, 24'd0};
			rem_q <= '0;
			cnt_q <= 6'(DivQW);
			neg_q <= diff[DataW];
			dz_q <= (dt_q <= DtW'(DtMinStep));
		end else if (cmd.div_step && cnt_q != 6'd0) begin
			if (rem_sh >= {1'b0, dt_q}) begin
				rem_q <= rem_sh - {1'b0, dt_q};
				quo_q <= {quo_q[DivQW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DivQW-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 6'd1;
		end
		if (cmd.dsat) deriv_q <= dz_q ? '0 : sat32(qs);
		if (cmd.mul_p) acc_q <= 66'(mul_r >>> FracBits);
		if (cmd.mul_i || cmd.mul_d) acc_q <= acc_q + 66'(mul_r >>> FracBits);
		if (cmd.clamp) begin
			if (acc_q > 66'(hi_q)) drive_q <= hi_q;
			else if (acc_q < 66'(lo_q)) drive_q <= lo_q;
			else drive_q <= acc_q[DataW-1:0];
		end
	end

	assign sts.div_done = cmd.div_step && (cnt_q == 6'd0);
	assign sts.kind = kind_q;
	assign drive = drive_q;

	a_sum_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.integ) |-> (sum_q <= $signed({1'b0, lim_q}) && sum_q >= -$signed({1'b0, lim_q})))
		else $error("integral beyond limit");
	a_short_dt: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.dsat) && $past(dz_q) |-> deriv_q == '0) else $error("derivative on short step");
	a_last_err: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.integ) |-> last_q == err_q) else $error("last error not updated");

endmodule

FILE: src/pid_controller_antiwindup.sv
// Channel | Dir | Payload
// smp     | in  | kind[1:0], value[31:0], dt_step[23:0]
// res     | out | drive[31:0]
// cfg     | in  | cfg_we, cfg_idx[2:0], cfg_data[31:0]
// A sample's result is offered after its steps: error, the dt product, the clamped
// integral, the one-bit-per-cycle restoring divider for the derivative (57 quotient
// bits), the gain products on the shared 32x32 multiplier (four products in all, with
// the dt product) and the output clamp. Set and clear items return to idle after the
// error step and give no result. One item is in flight at a time; the result waits in
// its register until taken. Reset clears state and gains and opens the bounds to full range at once.
module pid_controller_antiwindup import pid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	pid_if.sink                smp,
	pid_if.source              res,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [DataW-1:0]   cfg_data
);

	pid_cmd_t cmd;
	pid_sts_t sts;

	pid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (smp.valid),
		.in_ready  (smp.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pid_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_kind  (smp.data[1:0]),
		.in_value (smp.data[33:2]),
		.in_dt    (smp.data[57:34]),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.drive    (res.data)
	);

endmodule
